[sv/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and types of the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_WIDTH        = 16;
  localparam int NMAG_WIDTH       = 31;
  localparam int SUM_WIDTH        = 64;
  localparam int ROOT_WIDTH       = 32;
  localparam int ROOT_STEPS       = 32;
  localparam int ROOT_PER_STAGE   = 2;

  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
    logic       degen;
  } ctl_t;

endpackage

[sv/tun_cross.sv]
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, six products and the signed cross product, split into
// magnitudes, result signs and a zero flag over four stages.
// ----------------------------------------------------------------------------
module tun_cross #(
  parameter int  COORD_WIDTH = tun_pkg::COORD_WIDTH,
  localparam int EW = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1,
  localparam int MW = 2 * EW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH-1:0] a_x,
  input  logic [COORD_WIDTH-1:0] a_y,
  input  logic [COORD_WIDTH-1:0] a_z,
  input  logic [COORD_WIDTH-1:0] b_x,
  input  logic [COORD_WIDTH-1:0] b_y,
  input  logic [COORD_WIDTH-1:0] b_z,
  input  logic [COORD_WIDTH-1:0] c_x,
  input  logic [COORD_WIDTH-1:0] c_y,
  input  logic [COORD_WIDTH-1:0] c_z,
  input  logic                   outward,
  output tun_pkg::ctl_t          ctl,
  output logic [MW-1:0]          mag_x,
  output logic [MW-1:0]          mag_y,
  output logic [MW-1:0]          mag_z
);

  localparam int SH = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;

  function automatic logic signed [EW-1:0] edge_of(input logic [COORD_WIDTH-1:0] p,
                                                   input logic [COORD_WIDTH-1:0] q);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    d = DW'(signed'(q)) - DW'(signed'(p));
    m = d[DW-1] ? DW'(-d) : DW'(d);
    m = m >> SH;
    return signed'(EW'(d[DW-1] ? (~m + 1'b1) : m));
  endfunction

  logic                 s1_valid, s1_out;
  logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
  logic                 s2_valid, s2_out;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic                 s3_valid, s3_out;
  logic signed [XW-1:0] cx, cy, cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      ctl      <= '0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      ctl.valid <= s3_valid;
      ctl.neg[0] <= cx[XW-1] == s3_out && cx != '0;
      ctl.neg[1] <= cy[XW-1] == s3_out && cy != '0;
      ctl.neg[2] <= cz[XW-1] == s3_out && cz != '0;
      ctl.degen  <= cx == '0 && cy == '0 && cz == '0;
    end
  end

  always_ff @(posedge clk) begin
    s1_out <= outward;
    ux     <= edge_of(a_x, b_x);
    uy     <= edge_of(a_y, b_y);
    uz     <= edge_of(a_z, b_z);
    vx     <= edge_of(a_x, c_x);
    vy     <= edge_of(a_y, c_y);
    vz     <= edge_of(a_z, c_z);
    s2_out <= s1_out;
    p_yz   <= uy * vz;
    p_zy   <= uz * vy;
    p_zx   <= uz * vx;
    p_xz   <= ux * vz;
    p_xy   <= ux * vy;
    p_yx   <= uy * vx;
    s3_out <= s2_out;
    cx     <= XW'(p_yz) - XW'(p_zy);
    cy     <= XW'(p_zx) - XW'(p_xz);
    cz     <= XW'(p_xy) - XW'(p_yx);
    mag_x  <= cx[XW-1] ? MW'(-cx) : MW'(cx);
    mag_y  <= cy[XW-1] ? MW'(-cy) : MW'(cy);
    mag_z  <= cz[XW-1] ? MW'(-cz) : MW'(cz);
  end

endmodule

[sv/tun_norm.sv]
// ----------------------------------------------------------------------------
// tun_norm
// Common left shift of the three magnitudes, one power of two per stage,
// until the largest has its top bit set; the upper bits are kept.
// ----------------------------------------------------------------------------
module tun_norm #(
  parameter int  IN_WIDTH = 34,
  localparam int NW = (IN_WIDTH > tun_pkg::NMAG_WIDTH) ? IN_WIDTH : tun_pkg::NMAG_WIDTH,
  localparam int L  = $clog2(NW)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tun_pkg::ctl_t                  in_ctl,
  input  logic [IN_WIDTH-1:0]            in_x,
  input  logic [IN_WIDTH-1:0]            in_y,
  input  logic [IN_WIDTH-1:0]            in_z,
  output tun_pkg::ctl_t                  ctl,
  output logic [tun_pkg::NMAG_WIDTH-1:0] mag_x,
  output logic [tun_pkg::NMAG_WIDTH-1:0] mag_y,
  output logic [tun_pkg::NMAG_WIDTH-1:0] mag_z
);

  logic [NW-1:0] sx [L+1];
  logic [NW-1:0] sy [L+1];
  logic [NW-1:0] sz [L+1];
  tun_pkg::ctl_t sc [L+1];

  assign sx[0] = NW'(in_x);
  assign sy[0] = NW'(in_y);
  assign sz[0] = NW'(in_z);
  assign sc[0] = in_ctl;

  for (genvar k = 0; k < L; k++) begin : g_step
    localparam int SA = 1 << (L - 1 - k);
    logic [NW-1:0] any;
    logic          clear;
    assign any   = sx[k] | sy[k] | sz[k];
    assign clear = any[NW-1 -: SA] == '0;
    always_ff @(posedge clk) begin
      if (rst) begin
        sc[k+1] <= '0;
      end else begin
        sc[k+1] <= sc[k];
      end
    end
    always_ff @(posedge clk) begin
      sx[k+1] <= clear ? (sx[k] << SA) : sx[k];
      sy[k+1] <= clear ? (sy[k] << SA) : sy[k];
      sz[k+1] <= clear ? (sz[k] << SA) : sz[k];
    end
  end

  assign ctl   = sc[L];
  assign mag_x = sx[L][NW-1 -: tun_pkg::NMAG_WIDTH];
  assign mag_y = sy[L][NW-1 -: tun_pkg::NMAG_WIDTH];
  assign mag_z = sz[L][NW-1 -: tun_pkg::NMAG_WIDTH];

endmodule

[sv/tun_sqrt.sv]
// ----------------------------------------------------------------------------
// tun_sqrt
// Squares, their sum, and the exact integer root of the squared length,
// two root steps per stage.
// ----------------------------------------------------------------------------
module tun_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  tun_pkg::ctl_t                  in_ctl,
  input  logic [tun_pkg::NMAG_WIDTH-1:0] in_x,
  input  logic [tun_pkg::NMAG_WIDTH-1:0] in_y,
  input  logic [tun_pkg::NMAG_WIDTH-1:0] in_z,
  output tun_pkg::ctl_t                  ctl,
  output logic [tun_pkg::NMAG_WIDTH-1:0] mag_x,
  output logic [tun_pkg::NMAG_WIDTH-1:0] mag_y,
  output logic [tun_pkg::NMAG_WIDTH-1:0] mag_z,
  output logic [tun_pkg::ROOT_WIDTH-1:0] root
);

  localparam int MW = tun_pkg::NMAG_WIDTH;
  localparam int SW = tun_pkg::SUM_WIDTH;
  localparam int NS = tun_pkg::ROOT_STEPS / tun_pkg::ROOT_PER_STAGE;

  tun_pkg::ctl_t    q_ctl;
  logic [MW-1:0]    q_x, q_y, q_z;
  logic [2*MW-1:0]  sq_x, sq_y, sq_z;

  logic [SW-1:0]    rx  [NS+1];
  logic [SW-1:0]    rr  [NS+1];
  logic [MW-1:0]    mx  [NS+1];
  logic [MW-1:0]    my  [NS+1];
  logic [MW-1:0]    mz  [NS+1];
  tun_pkg::ctl_t    rc  [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ctl <= '0;
      rc[0] <= '0;
    end else begin
      q_ctl <= in_ctl;
      rc[0] <= q_ctl;
    end
  end

  always_ff @(posedge clk) begin
    q_x   <= in_x;
    q_y   <= in_y;
    q_z   <= in_z;
    sq_x  <= in_x * in_x;
    sq_y  <= in_y * in_y;
    sq_z  <= in_z * in_z;
    rx[0] <= SW'(sq_x) + SW'(sq_y) + SW'(sq_z);
    rr[0] <= '0;
    mx[0] <= q_x;
    my[0] <= q_y;
    mz[0] <= q_z;
  end

  for (genvar j = 0; j < NS; j++) begin : g_root
    localparam int B0 = SW - 2 - 4 * j;
    localparam int B1 = SW - 4 - 4 * j;
    logic [SW-1:0] t0, x1, r1, t1, x2, r2;
    always_comb begin
      t0 = rr[j] + (SW'(1) << B0);
      if (rx[j] >= t0) begin
        x1 = rx[j] - t0;
        r1 = (rr[j] >> 1) + (SW'(1) << B0);
      end else begin
        x1 = rx[j];
        r1 = rr[j] >> 1;
      end
      t1 = r1 + (SW'(1) << B1);
      if (x1 >= t1) begin
        x2 = x1 - t1;
        r2 = (r1 >> 1) + (SW'(1) << B1);
      end else begin
        x2 = x1;
        r2 = r1 >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rc[j+1] <= '0;
      end else begin
        rc[j+1] <= rc[j];
      end
    end
    always_ff @(posedge clk) begin
      rx[j+1] <= x2;
      rr[j+1] <= r2;
      mx[j+1] <= mx[j];
      my[j+1] <= my[j];
      mz[j+1] <= mz[j];
    end
  end

  assign ctl   = rc[NS];
  assign mag_x = mx[NS];
  assign mag_y = my[NS];
  assign mag_z = mz[NS];
  assign root  = rr[NS][tun_pkg::ROOT_WIDTH-1:0];

endmodule

[sv/tun_div.sv]
// ----------------------------------------------------------------------------
// tun_div
// Three rounded restoring dividers, one quotient bit per stage, then cap,
// sign and the zero-normal override into the result registers.
// ----------------------------------------------------------------------------
module tun_div #(
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tun_pkg::ctl_t                  in_ctl,
  input  logic [tun_pkg::NMAG_WIDTH-1:0] in_x,
  input  logic [tun_pkg::NMAG_WIDTH-1:0] in_y,
  input  logic [tun_pkg::NMAG_WIDTH-1:0] in_z,
  input  logic [tun_pkg::ROOT_WIDTH-1:0] root,
  output logic                           done,
  output logic [tun_pkg::OUT_WIDTH-1:0]  norm_x,
  output logic [tun_pkg::OUT_WIDTH-1:0]  norm_y,
  output logic [tun_pkg::OUT_WIDTH-1:0]  norm_z,
  output logic                           degenerate
);

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int MW   = tun_pkg::NMAG_WIDTH;
  localparam int DVW  = tun_pkg::ROOT_WIDTH;
  localparam int NUMW = MW + F + 1;
  localparam int RW   = DVW + 1;
  localparam int OW   = tun_pkg::OUT_WIDTH;
  localparam int TW   = (F + 2 > OW) ? F + 2 : OW;

  logic [NUMW-1:0] num [3];
  logic [RW-1:0]   rem [F+2][3];
  logic [F:0]      low [F+2][3];
  logic [F:0]      quo [F+2][3];
  logic [DVW-1:0]  dv  [F+2];
  tun_pkg::ctl_t   dc  [F+2];

  assign num[0] = (NUMW'(in_x) << F) + NUMW'(root >> 1);
  assign num[1] = (NUMW'(in_y) << F) + NUMW'(root >> 1);
  assign num[2] = (NUMW'(in_z) << F) + NUMW'(root >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dc[0] <= '0;
    end else begin
      dc[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    dv[0] <= root;
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= RW'(num[i] >> (F + 1));
      low[0][i] <= num[i][F:0];
      quo[0][i] <= '0;
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_bit
    logic [RW-1:0] trial [3];
    logic [2:0]    fit;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem[k][i][RW-2:0], low[k][i][F]};
        fit[i]   = trial[i] >= RW'(dv[k]);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dc[k+1] <= '0;
      end else begin
        dc[k+1] <= dc[k];
      end
    end
    always_ff @(posedge clk) begin
      dv[k+1] <= dv[k];
      for (int i = 0; i < 3; i++) begin
        rem[k+1][i] <= fit[i] ? trial[i] - RW'(dv[k]) : trial[i];
        low[k+1][i] <= low[k][i] << 1;
        quo[k+1][i] <= {quo[k][i][F-1:0], fit[i]};
      end
    end
  end

  logic [TW-1:0] res [3];

  always_comb begin
    logic [F:0] n;
    for (int i = 0; i < 3; i++) begin
      n = quo[F+1][i];
      if (n > ((F+1)'(1) << F)) begin
        n = (F+1)'(1) << F;
      end
      res[i] = dc[F+1].neg[i] ? TW'(~TW'(n) + 1'b1) : TW'(n);
      if (dc[F+1].degen) begin
        res[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dc[F+1].valid;
    end
  end

  always_ff @(posedge clk) begin
    norm_x     <= res[0][OW-1:0];
    norm_y     <= res[1][OW-1:0];
    norm_z     <= res[2][OW-1:0];
    degenerate <= dc[F+1].degen;
  end

endmodule

[sv/triangle_unit_normal_unit.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit
// Unit face normal of a triangle: edges, cross product, normalization by an
// exact integer root and rounded division, signed Q1.F components.
// ----------------------------------------------------------------------------
//  channel   ports                                   beat taken when
//  vertices  a_*, b_*, c_*, outward                  start && !busy
//  normal    norm_x, norm_y, norm_z, degenerate      done (one cycle)
//
//  A triangle enters every cycle; busy stays low.
//  The 32-step root (two steps a stage) and the one-bit-a-stage dividers set the
//  depth. Reset clears only the stage control words (valid, sign and zero flags).
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
module triangle_unit_normal_unit #(
  parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_WIDTH-1:0]        a_x,
  input  logic [COORD_WIDTH-1:0]        a_y,
  input  logic [COORD_WIDTH-1:0]        a_z,
  input  logic [COORD_WIDTH-1:0]        b_x,
  input  logic [COORD_WIDTH-1:0]        b_y,
  input  logic [COORD_WIDTH-1:0]        b_z,
  input  logic [COORD_WIDTH-1:0]        c_x,
  input  logic [COORD_WIDTH-1:0]        c_y,
  input  logic [COORD_WIDTH-1:0]        c_z,
  input  logic                          outward,
  output logic                          done,
  output logic [tun_pkg::OUT_WIDTH-1:0] norm_x,
  output logic [tun_pkg::OUT_WIDTH-1:0] norm_y,
  output logic [tun_pkg::OUT_WIDTH-1:0] norm_z,
  output logic                          degenerate
);

  localparam int EW  = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1;
  localparam int XMW = 2 * EW;
  localparam int NW  = (XMW > tun_pkg::NMAG_WIDTH) ? XMW : tun_pkg::NMAG_WIDTH;
  localparam int LAT = 4 + $clog2(NW) + 2
                       + tun_pkg::ROOT_STEPS / tun_pkg::ROOT_PER_STAGE
                       + NORMAL_FRAC_BITS + 3;

  localparam int MW = tun_pkg::NMAG_WIDTH;

  tun_pkg::ctl_t    x_ctl, n_ctl, s_ctl;
  logic [XMW-1:0]   x_x, x_y, x_z;
  logic [MW-1:0]    n_x, n_y, n_z;
  logic [MW-1:0]    s_x, s_y, s_z;
  logic [tun_pkg::ROOT_WIDTH-1:0] s_root;

  assign busy = 1'b0;

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .c_x      (c_x),
    .c_y      (c_y),
    .c_z      (c_z),
    .outward  (outward),
    .ctl      (x_ctl),
    .mag_x    (x_x),
    .mag_y    (x_y),
    .mag_z    (x_z)
  );

  tun_norm #(.IN_WIDTH(XMW)) u_norm (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (x_ctl),
    .in_x   (x_x),
    .in_y   (x_y),
    .in_z   (x_z),
    .ctl    (n_ctl),
    .mag_x  (n_x),
    .mag_y  (n_y),
    .mag_z  (n_z)
  );

  tun_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .in_ctl (n_ctl),
    .in_x   (n_x),
    .in_y   (n_y),
    .in_z   (n_z),
    .ctl    (s_ctl),
    .mag_x  (s_x),
    .mag_y  (s_y),
    .mag_z  (s_z),
    .root   (s_root)
  );

  tun_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (s_ctl),
    .in_x       (s_x),
    .in_y       (s_y),
    .in_z       (s_z),
    .root       (s_root),
    .done       (done),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
  );

`ifndef SYNTHESIS
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("degenerate beat with nonzero normal");

  a_live_nonzero : assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> (norm_x | norm_y | norm_z) != '0)
    else $error("nondegenerate beat with zero normal");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without matching start");

  a_never_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> !busy)
    else $error("busy raised");
`endif

endmodule

[tb/triangle_unit_normal_unit_test.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit_test
// Drives triangles into the unit normal pipeline, predicts each normal with
// an integer model of the cross product and normalization, and checks every
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_unit_normal_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tun_pkg::COORD_WIDTH;
  localparam int FB = tun_pkg::NORMAL_FRAC_BITS;
  localparam int OW = tun_pkg::OUT_WIDTH;
  localparam int DRAIN_CYCLES = 80;

  typedef logic [CW-1:0] coord_t;
  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t a_x = '0, a_y = '0, a_z = '0;
  coord_t b_x = '0, b_y = '0, b_z = '0;
  coord_t c_x = '0, c_y = '0, c_z = '0;
  logic outward = 1'b0;
  logic done;
  logic [OW-1:0] norm_x, norm_y, norm_z;
  logic degenerate;

  normal_t pending_normals[$];
  int errors = 0;
  bit idle_enable = 1'b1;

  triangle_unit_normal_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z), .outward(outward),
    .done(done), .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(coord_t ax, coord_t ay, coord_t az,
                                          coord_t bx, coord_t by, coord_t bz,
                                          coord_t cx, coord_t cy, coord_t cz,
                                          logic outw);
    longint ux, uy, uz, vx, vy, vz;
    longint cr[3];
    longint unsigned mag[3];
    longint unsigned m, s, r, n, one;
    bit neg[3];
    normal_t res;
    ux = longint'($signed(bx)) - longint'($signed(ax));
    uy = longint'($signed(by)) - longint'($signed(ay));
    uz = longint'($signed(bz)) - longint'($signed(az));
    vx = longint'($signed(cx)) - longint'($signed(ax));
    vy = longint'($signed(cy)) - longint'($signed(ay));
    vz = longint'($signed(cz)) - longint'($signed(az));
    cr[0] = uy * vz - uz * vy;
    cr[1] = uz * vx - ux * vz;
    cr[2] = ux * vy - uy * vx;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = ((cr[k] < 0) != !outw) && cr[k] != 0;
      mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
      if (mag[k] > m) m = mag[k];
    end
    res = '0;
    if (m == 0) begin
      res.degen = 1'b1;
      return res;
    end
    while (m >= (64'd1 << 31)) begin
      m >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = int_sqrt(s);
    one = 64'd1 << FB;
    for (int k = 0; k < 3; k++) begin
      n = ((mag[k] << FB) + (r >> 1)) / r;
      if (n > one) n = one;
      if (neg[k]) n = -n;
      if (k == 0) res.nx = n[OW-1:0];
      else if (k == 1) res.ny = n[OW-1:0];
      else res.nz = n[OW-1:0];
    end
    return res;
  endfunction

  task automatic report(string what, logic [OW-1:0] got, logic [OW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic idle_burst();
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic send_triangle(coord_t ax, coord_t ay, coord_t az,
                               coord_t bx, coord_t by, coord_t bz,
                               coord_t cx, coord_t cy, coord_t cz, logic outw);
    start <= 1'b1;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    c_x <= cx; c_y <= cy; c_z <= cz;
    outward <= outw;
    do @(posedge clk); while (busy);
    pending_normals.push_back(face_normal(ax, ay, az, bx, by, bz, cx, cy, cz, outw));
    @(negedge clk);
    idle_burst();
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom_range(0, 7) - 4);
      1: return coord_t'($urandom_range(0, 2047) - 1024);
      2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return coord_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    normal_t want;
    if (!rst && done) begin
      if (pending_normals.size() == 0) begin
        $display("unexpected normal beat at %0t", $realtime);
        errors++;
      end else begin
        want = pending_normals.pop_front();
        if (norm_x !== want.nx) report("norm_x", norm_x, want.nx);
        if (norm_y !== want.ny) report("norm_y", norm_y, want.ny);
        if (norm_z !== want.nz) report("norm_z", norm_z, want.nz);
        if (degenerate !== want.degen)
          report("degenerate", OW'(degenerate), OW'(want.degen));
      end
    end
  end

  task automatic test_directed();
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b1);
    send_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b0);
    send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    send_triangle(5, 5, 5, 5, 5, 5, 9, 1, 3, 1'b1);
    send_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2, 1'b0);
    send_triangle(mn, mn, mn, mx, mn, mn, mn, mx, mn, 1'b1);
    send_triangle(mn, mn, mn, mx, mx, mn, mn, mx, mx, 1'b0);
    send_triangle(mx, mx, mx, mn, mn, mn, mn, mx, mn, 1'b1);
    send_triangle(mn, mx, mn, mx, mn, mx, mx, mx, mn, 1'b0);
    send_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1);
    send_triangle(0, 0, 0, 1, 0, 0, 0, 0, 1, 1'b0);
    send_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1, 1'b1);
    send_triangle(0, 0, 0, 1, 0, 0, 1, 1, 0, 1'b1);
    send_triangle('1, '1, '1, '0, '0, '0, '1, '0, '1, 1'b0);
    send_triangle(0, 0, 0, 3, 1, 0, 1, 3, 1, 1'b1);
  endtask

  task automatic test_random(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0)
        send_triangle(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      rand_coord(mode), rand_coord(mode), rand_coord(mode),
                      1'($urandom));
      else begin
        coord_t px, py, pz;
        px = rand_coord(mode); py = rand_coord(mode); pz = rand_coord(mode);
        if ($urandom_range(0, 9) == 0)
          send_triangle(px, py, pz, coord_t'(px + 2), coord_t'(py + 4), coord_t'(pz + 6),
                        coord_t'(px + 1), coord_t'(py + 2), coord_t'(pz + 3),
                        1'($urandom));
        else
          send_triangle(px, py, pz, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                        rand_coord(mode), rand_coord(mode), rand_coord(mode),
                        1'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
  endtask

  initial begin
    #200000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    wait_drained();
    test_random(500);
    idle_enable = 1'b0;
    test_random(200);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
sv/tun_pkg.sv
sv/tun_cross.sv
sv/tun_norm.sv
sv/tun_sqrt.sv
sv/tun_div.sv
sv/triangle_unit_normal_unit.sv
tb/triangle_unit_normal_unit_test.sv
